// ===== hdl/pap_pkg.sv =====
// shared constants, types and helpers for the polyline area point query block
`timescale 1ns / 1ps
package pap_pkg;

	localparam int MAX_STATIONS = 64;
	localparam int FRAC_BITS    = 16;

	localparam int ADDR_W  = $clog2(MAX_STATIONS);
	localparam int CNT_W   = $clog2(MAX_STATIONS + 1);
	localparam int XW      = 32;
	localparam int WW      = 31;
	localparam int DW      = XW + 1;
	localparam int MW      = XW + 2;
	localparam int PW      = 2 * MW;
	localparam int TW      = FRAC_BITS + 1;
	localparam int RAM_W   = 3 * XW + WW;
	localparam int REM_W   = PW;
	localparam int DEN_W   = PW - 1;
	localparam int NUM_W   = 48;
	localparam int ROOT_W  = 32;
	localparam int SQ_W    = 2 * ROOT_W - 1;
	localparam int STEP_W  = 6;
	localparam int FW      = 18;
	localparam int FLOW_SH = 16;
	localparam int FLOW_ONE = 1 << FLOW_SH;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ANSW  = 2'd2;

	localparam logic REG_CLOSED_MODE = 1'b0;
	localparam logic REG_FLAT_HEIGHT = 1'b1;

	typedef enum logic {IT_DIV, IT_SQRT} iter_mode_t;

	typedef struct packed {
		logic              start;
		iter_mode_t        mode;
		logic [REM_W-1:0]  rem0;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} iter_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quo;
		logic [ROOT_W-1:0] root;
	} iter_rsp_t;

	// difference of two signed words, one bit wider
	function automatic logic signed [DW-1:0] dif33(input logic signed [XW-1:0] a,
		input logic signed [XW-1:0] b);
		return $signed({a[XW-1], a}) - $signed({b[XW-1], b});
	endfunction

	function automatic logic signed [MW-1:0] ext34(input logic signed [DW-1:0] a);
		return $signed({a[DW-1], a});
	endfunction

	function automatic logic signed [PW-1:0] ext68(input logic signed [XW-1:0] a);
		return $signed({{(PW-XW){a[XW-1]}}, a});
	endfunction

endpackage

// ===== hdl/pap_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ===== hdl/pap_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module pap_mul (
	input  logic                            clk,
	input  logic signed [pap_pkg::MW-1:0]   a,
	input  logic signed [pap_pkg::MW-1:0]   b,
	output logic signed [pap_pkg::PW-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== hdl/pap_iter.sv =====
// iterative unit: restoring divide one quotient bit per cycle, or square root one bit per cycle
`timescale 1ns / 1ps
module pap_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  pap_pkg::iter_req_t  req,
	output pap_pkg::iter_rsp_t  rsp
);

	logic                        busy_q;
	logic                        done_q;
	pap_pkg::iter_mode_t         mode_q;
	logic [pap_pkg::STEP_W-1:0]  cnt_q;
	logic [pap_pkg::REM_W-1:0]   rem_q;
	logic [pap_pkg::NUM_W-1:0]   num_q;
	logic [pap_pkg::DEN_W-1:0]   den_q;
	logic [pap_pkg::NUM_W-1:0]   quo_q;
	logic [pap_pkg::SQ_W-1:0]    root_q;
	logic [pap_pkg::SQ_W-1:0]    bit_q;

	logic [pap_pkg::REM_W-1:0]   r2;
	logic                        ge;
	logic [pap_pkg::SQ_W:0]      trial;
	logic                        sq_ge;

	always_comb begin
		r2    = {rem_q[pap_pkg::REM_W-2:0], num_q[pap_pkg::NUM_W-1]};
		ge    = r2 >= {1'b0, den_q};
		trial = {1'b0, root_q} + {1'b0, bit_q};
		sq_ge = rem_q[pap_pkg::SQ_W:0] >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= pap_pkg::IT_DIV;
			cnt_q  <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			root_q <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.mode;
				cnt_q  <= req.steps;
				rem_q  <= req.rem0;
				num_q  <= req.num;
				den_q  <= req.den;
				quo_q  <= '0;
				root_q <= '0;
				bit_q  <= {1'b1, {(pap_pkg::SQ_W-1){1'b0}}};
			end else if (busy_q) begin
				unique case (mode_q)
					pap_pkg::IT_DIV: begin
						rem_q <= ge ? r2 - {1'b0, den_q} : r2;
						quo_q <= {quo_q[pap_pkg::NUM_W-2:0], ge};
						num_q <= {num_q[pap_pkg::NUM_W-2:0], 1'b0};
					end
					pap_pkg::IT_SQRT: begin
						if (sq_ge) begin
							rem_q  <= {{(pap_pkg::REM_W-pap_pkg::SQ_W-1){1'b0}},
								rem_q[pap_pkg::SQ_W:0] - trial};
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
					default: ;
				endcase
				cnt_q <= cnt_q - pap_pkg::STEP_W'(1);
				if (cnt_q == pap_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.root = root_q[pap_pkg::ROOT_W-1:0];

endmodule

// ===== hdl/polyline_area_point_query.sv =====
// top level: station store, query sequencer, shared multiplier and divide/root unit
`timescale 1ns / 1ps
// usage:
//  request channel: drive op and the position fields with start; a request is taken
//   at a clock edge with start high and busy low. busy stays high while a query runs.
//  result channel: done pulses for one cycle with status and the answer fields; the
//   receiver takes it in that cycle and cannot hold it off.
//  config channel: cfg_valid/cfg_index/cfg_data, cfg_ready is always high; write only
//   while no request is in flight.
//  clear, add and any query with fewer than two stations answer in the cycle after
//   the request and busy never rises, so these run one per cycle.
//  closed-mode query: S_C_WP, S_C_LP, then S_C_WT to S_C_CMP per station.
//  open-mode query: S_O_WP, S_O_LP, then per segment S_O_WT to S_O_M5, S_O_DIV
//   only when t needs a divide, and S_O_NX to S_O_D4; then height and flow
//   (normalize shifts, 32 root steps, two 48-step divides). the shared multiplier
//   gives one product a cycle and the divide/root unit is bit-serial.
//  reset: station count cleared, closed mode on, flat height zero; the store itself
//   is not cleared and needs no sweep.
module polyline_area_point_query (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic signed [31:0]       pos_x,
	input  logic signed [31:0]       pos_y,
	input  logic signed [31:0]       pos_z,
	input  logic [30:0]              station_width,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [31:0]              cfg_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     inside_res,
	output logic                     height_valid,
	output logic signed [31:0]       surface_height,
	output logic                     flow_valid,
	output logic signed [17:0]       flow_x,
	output logic signed [17:0]       flow_y
);

	typedef enum logic [5:0] {
		S_IDLE,
		S_C_WP, S_C_LP, S_C_WT, S_C_CUR, S_C_M2, S_C_CMP,
		S_O_WP, S_O_LP, S_O_WT, S_O_CUR, S_O_M1, S_O_M2, S_O_M3, S_O_M4, S_O_M5,
		S_O_DIV, S_O_NX, S_O_NY, S_O_DX, S_O_D1, S_O_D2, S_O_D3, S_O_D4,
		S_H1, S_H2, S_NORM, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_FX, S_FXW, S_FY, S_FYW
	} state_t;

	state_t state_q;

	// configuration
	logic                           closed_q;
	logic signed [31:0]             flat_q;

	// store bookkeeping
	logic [pap_pkg::CNT_W-1:0]      count_q;
	logic [pap_pkg::ADDR_W-1:0]     rd_addr_q;
	logic [pap_pkg::ADDR_W-1:0]     idx_q;
	logic [pap_pkg::RAM_W-1:0]      rd_data;
	logic                           ram_we;

	// query point and segment ends (a = previous station, b = current)
	logic signed [31:0]             qx_q, qy_q;
	logic signed [31:0]             ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic [30:0]                    aw_q, bw_q;
	logic signed [pap_pkg::DW-1:0]  sx_q, sy_q;
	logic signed [pap_pkg::PW-1:0]  acc_q, len2_q;
	logic [pap_pkg::TW-1:0]         t_q;
	logic signed [pap_pkg::MW-1:0]  dx_q, dy_q, w_q;
	logic [pap_pkg::PW-1:0]         d2_q, best_d2_q;
	logic                           inside_q, cond_q, dyp_q;

	// nearest segment
	logic [pap_pkg::TW-1:0]         best_t_q;
	logic signed [31:0]             bza_q, bzb_q;
	logic signed [pap_pkg::DW-1:0]  bsx_q, bsy_q;
	logic signed [31:0]             h_q;

	// flow
	logic [pap_pkg::DW-1:0]         mx_q, my_q;
	logic [pap_pkg::ROOT_W-1:0]     l_q;
	logic [16:0]                    rx_q;

	// result registers
	logic                           done_q, inside_o_q, hv_q, fv_q;
	logic [1:0]                     status_q;
	logic signed [31:0]             height_q;
	logic signed [17:0]             fx_q, fy_q;

	logic signed [pap_pkg::MW-1:0]  mul_a, mul_b;
	logic signed [pap_pkg::PW-1:0]  p_q;
	pap_pkg::iter_req_t             iter_req;
	pap_pkg::iter_rsp_t             iter_rsp;

	logic signed [31:0]             rd_x, rd_y, rd_z;
	logic [30:0]                    rd_w;
	logic signed [pap_pkg::PW-1:0]  p_sh, dot;
	logic signed [pap_pkg::MW-1:0]  t_s, bt_s;
	logic                           accept, seg_last, ring_last, left, tog;
	logic [pap_pkg::DW-1:0]         m_max;
	logic [pap_pkg::NUM_W-1:0]      q_clamp_src;
	logic [16:0]                    q_clamp;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ram_we    = accept && (op == pap_pkg::OP_ADD) &&
		(count_q < pap_pkg::CNT_W'(pap_pkg::MAX_STATIONS));

	pap_ram #(.WIDTH(pap_pkg::RAM_W), .DEPTH(pap_pkg::MAX_STATIONS)) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (count_q[pap_pkg::ADDR_W-1:0]),
		.wdata   ({pos_x, pos_y, pos_z, station_width}),
		.raddr   (rd_addr_q),
		.rdata_q (rd_data)
	);

	pap_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(p_q));

	pap_iter u_iter (.clk(clk), .arst_n(arst_n), .req(iter_req), .rsp(iter_rsp));

	always_comb begin
		rd_x = rd_data[pap_pkg::RAM_W-1 -: 32];
		rd_y = rd_data[pap_pkg::RAM_W-33 -: 32];
		rd_z = rd_data[pap_pkg::RAM_W-65 -: 32];
		rd_w = rd_data[30:0];
		p_sh = p_q >>> pap_pkg::FRAC_BITS;
		dot  = acc_q + p_q;
		t_s  = $signed({{(pap_pkg::MW-pap_pkg::TW){1'b0}}, t_q});
		bt_s = $signed({{(pap_pkg::MW-pap_pkg::TW){1'b0}}, best_t_q});
		seg_last  = pap_pkg::CNT_W'(idx_q) == count_q - pap_pkg::CNT_W'(2);
		ring_last = pap_pkg::CNT_W'(idx_q) == count_q - pap_pkg::CNT_W'(1);
		// crossing side test, sign of the edge's y span picks the order
		left = dyp_q ? (acc_q < p_q) : (p_q < acc_q);
		tog  = cond_q && left;
		m_max = (mx_q > my_q) ? mx_q : my_q;
		q_clamp_src = iter_rsp.quo;
		q_clamp = (q_clamp_src > pap_pkg::NUM_W'(pap_pkg::FLOW_ONE)) ?
			17'(pap_pkg::FLOW_ONE) : q_clamp_src[16:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_C_CUR: begin
				mul_a = pap_pkg::ext34(pap_pkg::dif33(qx_q, rd_x));
				mul_b = pap_pkg::ext34(pap_pkg::dif33(ay_q, rd_y));
			end
			S_C_M2: begin
				mul_a = pap_pkg::ext34(pap_pkg::dif33(qy_q, by_q));
				mul_b = pap_pkg::ext34(pap_pkg::dif33(ax_q, bx_q));
			end
			S_O_M1: begin
				mul_a = pap_pkg::ext34(sx_q);
				mul_b = pap_pkg::ext34(sx_q);
			end
			S_O_M2: begin
				mul_a = pap_pkg::ext34(sy_q);
				mul_b = pap_pkg::ext34(sy_q);
			end
			S_O_M3: begin
				mul_a = pap_pkg::ext34(pap_pkg::dif33(qx_q, ax_q));
				mul_b = pap_pkg::ext34(sx_q);
			end
			S_O_M4: begin
				mul_a = pap_pkg::ext34(pap_pkg::dif33(qy_q, ay_q));
				mul_b = pap_pkg::ext34(sy_q);
			end
			S_O_NX: begin
				mul_a = t_s;
				mul_b = pap_pkg::ext34(sx_q);
			end
			S_O_NY: begin
				mul_a = t_s;
				mul_b = pap_pkg::ext34(sy_q);
			end
			S_O_DX: begin
				mul_a = t_s;
				mul_b = pap_pkg::ext34(pap_pkg::dif33($signed({1'b0, bw_q}),
					$signed({1'b0, aw_q})));
			end
			S_O_D1: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			S_O_D2: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			S_O_D3: begin
				mul_a = w_q;
				mul_b = w_q;
			end
			S_H1: begin
				mul_a = bt_s;
				mul_b = pap_pkg::ext34(pap_pkg::dif33(bzb_q, bza_q));
			end
			S_SQ1: begin
				mul_a = $signed({1'b0, mx_q});
				mul_b = $signed({1'b0, mx_q});
			end
			S_SQ2: begin
				mul_a = $signed({1'b0, my_q});
				mul_b = $signed({1'b0, my_q});
			end
			default: ;
		endcase
	end

	// requests to the divide/root unit
	always_comb begin
		iter_req       = '0;
		iter_req.mode  = pap_pkg::IT_DIV;
		unique case (state_q)
			S_O_M5: begin
				iter_req.start = (len2_q != '0) && (dot > 0) && (dot < len2_q);
				iter_req.rem0  = dot;
				iter_req.den   = len2_q[pap_pkg::DEN_W-1:0];
				iter_req.steps = pap_pkg::STEP_W'(pap_pkg::FRAC_BITS);
			end
			S_SQ3: begin
				iter_req.start = 1'b1;
				iter_req.mode  = pap_pkg::IT_SQRT;
				iter_req.rem0  = acc_q + p_q;
				iter_req.steps = pap_pkg::STEP_W'(pap_pkg::ROOT_W);
			end
			S_FX, S_FY: begin
				iter_req.start = 1'b1;
				iter_req.num   = (pap_pkg::NUM_W'(state_q == S_FX ? mx_q : my_q)
					<< pap_pkg::FLOW_SH) + pap_pkg::NUM_W'(l_q >> 1);
				iter_req.den   = pap_pkg::DEN_W'(l_q);
				iter_req.steps = pap_pkg::STEP_W'(pap_pkg::NUM_W);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			closed_q   <= 1'b1;
			flat_q     <= '0;
			count_q    <= '0;
			rd_addr_q  <= '0;
			idx_q      <= '0;
			qx_q <= '0; qy_q <= '0;
			ax_q <= '0; ay_q <= '0; az_q <= '0; aw_q <= '0;
			bx_q <= '0; by_q <= '0; bz_q <= '0; bw_q <= '0;
			sx_q <= '0; sy_q <= '0;
			acc_q <= '0; len2_q <= '0; t_q <= '0;
			dx_q <= '0; dy_q <= '0; w_q <= '0;
			d2_q <= '0; best_d2_q <= '0;
			inside_q <= 1'b0; cond_q <= 1'b0; dyp_q <= 1'b0;
			best_t_q <= '0; bza_q <= '0; bzb_q <= '0; bsx_q <= '0; bsy_q <= '0;
			h_q <= '0; mx_q <= '0; my_q <= '0; l_q <= '0; rx_q <= '0;
			done_q <= 1'b0; status_q <= pap_pkg::ST_DONE; inside_o_q <= 1'b0;
			hv_q <= 1'b0; height_q <= '0; fv_q <= 1'b0; fx_q <= '0; fy_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pap_pkg::REG_CLOSED_MODE: closed_q <= cfg_data[0];
					pap_pkg::REG_FLAT_HEIGHT: flat_q   <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						qx_q       <= pos_x;
						qy_q       <= pos_y;
						inside_q   <= 1'b0;
						status_q   <= pap_pkg::ST_DONE;
						inside_o_q <= 1'b0;
						hv_q       <= 1'b0;
						height_q   <= '0;
						fv_q       <= 1'b0;
						fx_q       <= '0;
						fy_q       <= '0;
						case (op)
							pap_pkg::OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							pap_pkg::OP_ADD: begin
								if (ram_we) begin
									count_q <= count_q + pap_pkg::CNT_W'(1);
								end else begin
									status_q <= pap_pkg::ST_FULL;
								end
								done_q <= 1'b1;
							end
							pap_pkg::OP_QUERY: begin
								if (count_q < pap_pkg::CNT_W'(2)) begin
									// too few stations: closed still answers flat height
									status_q <= pap_pkg::ST_ANSW;
									hv_q     <= closed_q;
									fv_q     <= closed_q;
									height_q <= closed_q ? flat_q : '0;
									done_q   <= 1'b1;
								end else if (closed_q) begin
									rd_addr_q <= pap_pkg::ADDR_W'(count_q - pap_pkg::CNT_W'(1));
									state_q   <= S_C_WP;
								end else begin
									rd_addr_q <= '0;
									state_q   <= S_O_WP;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end

				// ring walk: previous vertex first, then vertices 0 .. count-1
				S_C_WP: state_q <= S_C_LP;
				S_C_LP: begin
					ax_q      <= rd_x;
					ay_q      <= rd_y;
					idx_q     <= '0;
					rd_addr_q <= '0;
					state_q   <= S_C_WT;
				end
				S_C_WT: state_q <= S_C_CUR;
				S_C_CUR: begin
					bx_q    <= rd_x;
					by_q    <= rd_y;
					cond_q  <= (rd_y > qy_q) != (ay_q > qy_q);
					dyp_q   <= pap_pkg::dif33(ay_q, rd_y) > 0;
					state_q <= S_C_M2;
				end
				S_C_M2: begin
					acc_q   <= p_q;
					state_q <= S_C_CMP;
				end
				S_C_CMP: begin
					inside_q <= inside_q ^ tog;
					ax_q     <= bx_q;
					ay_q     <= by_q;
					if (ring_last) begin
						status_q   <= pap_pkg::ST_ANSW;
						inside_o_q <= inside_q ^ tog;
						hv_q       <= 1'b1;
						height_q   <= flat_q;
						fv_q       <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						idx_q     <= idx_q + pap_pkg::ADDR_W'(1);
						rd_addr_q <= idx_q + pap_pkg::ADDR_W'(1);
						state_q   <= S_C_WT;
					end
				end

				// polyline walk over segments 0 .. count-2
				S_O_WP: state_q <= S_O_LP;
				S_O_LP: begin
					ax_q      <= rd_x;
					ay_q      <= rd_y;
					az_q      <= rd_z;
					aw_q      <= rd_w;
					idx_q     <= '0;
					rd_addr_q <= pap_pkg::ADDR_W'(1);
					state_q   <= S_O_WT;
				end
				S_O_WT: state_q <= S_O_CUR;
				S_O_CUR: begin
					bx_q    <= rd_x;
					by_q    <= rd_y;
					bz_q    <= rd_z;
					bw_q    <= rd_w;
					sx_q    <= pap_pkg::dif33(rd_x, ax_q);
					sy_q    <= pap_pkg::dif33(rd_y, ay_q);
					state_q <= S_O_M1;
				end
				S_O_M1: state_q <= S_O_M2;
				S_O_M2: begin
					acc_q   <= p_q;
					state_q <= S_O_M3;
				end
				S_O_M3: begin
					len2_q  <= acc_q + p_q;
					state_q <= S_O_M4;
				end
				S_O_M4: begin
					acc_q   <= p_q;
					state_q <= S_O_M5;
				end
				S_O_M5: begin
					// clamp t to [0, 1]; zero-length segment uses t = 0
					if (len2_q == '0 || dot <= 0) begin
						t_q     <= '0;
						state_q <= S_O_NX;
					end else if (dot >= len2_q) begin
						t_q     <= pap_pkg::TW'(1) << pap_pkg::FRAC_BITS;
						state_q <= S_O_NX;
					end else begin
						state_q <= S_O_DIV;
					end
				end
				S_O_DIV: begin
					if (iter_rsp.done) begin
						t_q     <= iter_rsp.quo[pap_pkg::TW-1:0];
						state_q <= S_O_NX;
					end
				end
				S_O_NX: state_q <= S_O_NY;
				S_O_NY: begin
					dx_q    <= pap_pkg::MW'(pap_pkg::ext68(qx_q) - (pap_pkg::ext68(ax_q) + p_sh));
					state_q <= S_O_DX;
				end
				S_O_DX: begin
					dy_q    <= pap_pkg::MW'(pap_pkg::ext68(qy_q) - (pap_pkg::ext68(ay_q) + p_sh));
					state_q <= S_O_D1;
				end
				S_O_D1: begin
					w_q     <= pap_pkg::MW'(pap_pkg::ext68($signed({1'b0, aw_q})) + p_sh);
					state_q <= S_O_D2;
				end
				S_O_D2: begin
					acc_q   <= p_q;
					state_q <= S_O_D3;
				end
				S_O_D3: begin
					d2_q    <= acc_q + p_q;
					state_q <= S_O_D4;
				end
				S_O_D4: begin
					// capsule: 4 * dist^2 <= width^2
					if ({2'b00, p_q} >= {d2_q, 2'b00}) begin
						inside_q <= 1'b1;
					end
					// strict compare keeps the lower segment on a tie
					if (idx_q == '0 || d2_q < best_d2_q) begin
						best_d2_q <= d2_q;
						best_t_q  <= t_q;
						bza_q     <= az_q;
						bzb_q     <= bz_q;
						bsx_q     <= sx_q;
						bsy_q     <= sy_q;
					end
					ax_q <= bx_q;
					ay_q <= by_q;
					az_q <= bz_q;
					aw_q <= bw_q;
					if (seg_last) begin
						state_q <= S_H1;
					end else begin
						idx_q     <= idx_q + pap_pkg::ADDR_W'(1);
						rd_addr_q <= idx_q + pap_pkg::ADDR_W'(2);
						state_q   <= S_O_WT;
					end
				end

				// height on the nearest segment, then its flow direction
				S_H1: state_q <= S_H2;
				S_H2: begin
					h_q  <= 32'(pap_pkg::ext68(bza_q) + p_sh);
					mx_q <= bsx_q[pap_pkg::DW-1] ? pap_pkg::DW'(-bsx_q) : pap_pkg::DW'(bsx_q);
					my_q <= bsy_q[pap_pkg::DW-1] ? pap_pkg::DW'(-bsy_q) : pap_pkg::DW'(bsy_q);
					if (bsx_q == '0 && bsy_q == '0) begin
						status_q   <= pap_pkg::ST_ANSW;
						inside_o_q <= inside_q;
						hv_q       <= 1'b1;
						height_q   <= 32'(pap_pkg::ext68(bza_q) + p_sh);
						fv_q       <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// bring the larger magnitude into [2^30, 2^31)
					if (m_max[pap_pkg::DW-1:31] != '0) begin
						mx_q <= mx_q >> 1;
						my_q <= my_q >> 1;
					end else if (!m_max[30]) begin
						mx_q <= mx_q << 1;
						my_q <= my_q << 1;
					end else begin
						state_q <= S_SQ1;
					end
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: begin
					acc_q   <= p_q;
					state_q <= S_SQ3;
				end
				S_SQ3: state_q <= S_SQRT;
				S_SQRT: begin
					if (iter_rsp.done) begin
						l_q     <= iter_rsp.root;
						state_q <= S_FX;
					end
				end
				S_FX: state_q <= S_FXW;
				S_FXW: begin
					if (iter_rsp.done) begin
						rx_q    <= q_clamp;
						state_q <= S_FY;
					end
				end
				S_FY: state_q <= S_FYW;
				S_FYW: begin
					if (iter_rsp.done) begin
						status_q   <= pap_pkg::ST_ANSW;
						inside_o_q <= inside_q;
						hv_q       <= 1'b1;
						height_q   <= h_q;
						fv_q       <= 1'b1;
						fx_q       <= bsx_q[pap_pkg::DW-1] ? -$signed({1'b0, rx_q}) :
							$signed({1'b0, rx_q});
						fy_q       <= bsy_q[pap_pkg::DW-1] ? -$signed({1'b0, q_clamp}) :
							$signed({1'b0, q_clamp});
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign inside_res     = inside_o_q;
	assign height_valid   = hv_q;
	assign surface_height = height_q;
	assign flow_valid     = fv_q;
	assign flow_x         = fx_q;
	assign flow_y         = fy_q;

`ifndef ASSERT_OFF
	// a result always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while sequencer busy");

	// the station count never passes the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pap_pkg::CNT_W'(pap_pkg::MAX_STATIONS))
		else $error("station count overflow");

	// the divide/root unit only finishes while the sequencer waits for it
	a_iter_wait: assert property (@(posedge clk) disable iff (!arst_n)
		iter_rsp.done |-> (state_q == S_O_DIV || state_q == S_SQRT ||
			state_q == S_FXW || state_q == S_FYW))
		else $error("divide/root result not awaited");
`endif

endmodule
